// ===== hdl/sdm_pkg.sv =====
// Package for the signed divider: payload types, mode codes and special constants.
// No dependencies.
package sdm_pkg;
	localparam int W = 64;
	localparam logic [1:0] OP_32_32 = 2'd0;
	localparam logic [1:0] OP_64_32 = 2'd1;
	localparam logic [1:0] OP_64_64 = 2'd2;
	localparam logic [1:0] OP_64_32B = 2'd3;
	localparam logic [63:0] HIGH_WORD = 64'hFFFF_FFFF_0000_0000;
	localparam logic [63:0] MODE0_OVF_QUO = 64'h0000_0000_8000_0000;
	localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [1:0] op;
		logic signed [63:0] numerator;
		logic signed [63:0] denominator;
	} req_t;

	typedef struct packed {
		logic signed [63:0] quotient;
		logic signed [63:0] remainder;
		logic zero_divisor;
	} rsp_t;

	// per-item side info carried down the pipe
	typedef struct packed {
		logic special;
		logic [63:0] sq;
		logic [63:0] sr;
		logic qneg;
		logic rneg;
		logic zflag;
	} ctl_t;
endpackage

// ===== hdl/sdm_if.sv =====
// Valid/ready channel carrying one item of type T.
// Depends on sdm_pkg for payload types.
interface sdm_if #(parameter type T = sdm_pkg::req_t) (input logic clk);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/sdm_pre.sv =====
// Front stage: operand selection, special cases, magnitudes.
// Depends on sdm_pkg.
module sdm_pre (
	input sdm_pkg::req_t req,
	output logic [63:0] an,
	output logic [63:0] ad,
	output sdm_pkg::ctl_t ctl
);
	logic [63:0] n, d;
	logic nneg, dneg;
	always_comb begin
		unique case (req.op)
			sdm_pkg::OP_32_32: begin
				n = {{32{req.numerator[31]}}, req.numerator[31:0]};
				d = {{32{req.denominator[31]}}, req.denominator[31:0]};
			end
			sdm_pkg::OP_64_64: begin
				n = req.numerator;
				d = req.denominator;
			end
			default: begin
				n = req.numerator;
				d = {{32{req.denominator[31]}}, req.denominator[31:0]};
			end
		endcase
		nneg = n[63];
		dneg = d[63];
		an = nneg ? 64'(-n) : n;
		ad = dneg ? 64'(-d) : d;
		ctl.qneg = nneg ^ dneg;
		ctl.rneg = nneg;
		ctl.zflag = (req.denominator == '0);
		ctl.special = 1'b1;
		ctl.sr = '0;
		ctl.sq = '0;
		if (d == '0) begin
			ctl.sq = nneg ? 64'd1 : '1;
			if (req.op == sdm_pkg::OP_32_32) ctl.sq = ctl.sq ^ sdm_pkg::HIGH_WORD;
			ctl.sr = n;
		end else if (req.op == sdm_pkg::OP_32_32 && n[31:0] == 32'h8000_0000 && d == '1) begin
			ctl.sq = sdm_pkg::MODE0_OVF_QUO;
		end else if (n == sdm_pkg::SIGN64 && d == '1) begin
			ctl.sq = sdm_pkg::SIGN64;
		end else begin
			ctl.special = 1'b0;
		end
	end
endmodule

// ===== hdl/sdm_stage.sv =====
// One restoring-division stage: K quotient bits per register stage.
// Depends on sdm_pkg.
module sdm_stage #(parameter int K = 4) (
	input logic clk,
	input logic en,
	input logic [63:0] rem_i,
	input logic [63:0] num_i,
	input logic [63:0] den_i,
	input sdm_pkg::ctl_t ctl_i,
	output logic [63:0] rem_s1,
	output logic [63:0] num_s1,
	output logic [63:0] den_s1,
	output sdm_pkg::ctl_t ctl_s1
);
	logic [63:0] r, nm;
	logic [64:0] t;
	always_comb begin
		r = rem_i;
		nm = num_i;
		t = '0;
		for (int i = 0; i < K; i++) begin
			t = {r, nm[63]};
			nm = {nm[62:0], 1'b0};
			if (t >= {1'b0, den_i}) begin
				t = t - {1'b0, den_i};
				nm[0] = 1'b1;
			end
			r = t[63:0];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= r;
			num_s1 <= nm;
			den_s1 <= den_i;
			ctl_s1 <= ctl_i;
		end
	end
endmodule

// ===== hdl/signed_divider_with_modes_top.sv =====
// Signed divider top: pipeline of 16 division stages plus input and output registers.
// Depends on sdm_pkg, sdm_if, sdm_pre, sdm_stage.
//
// Fully pipelined signed 64-bit divider. One item is accepted per cycle while the
// output is not stalled. The path is an input register, 16 stages of four
// restoring quotient bits each, and an output register; latency is set by that
// stage chain. The pipeline stalls as a whole when the output is not taken, so no
// item is lost or repeated. Mode 0 is 32/32, modes 1 and 3 are 64/32, mode 2 is
// 64/64; divide by zero and min/-1 overflow give fixed results, and zero_divisor
// tests the full 64-bit denominator.
module signed_divider_with_modes_top (
	input logic clk,
	input logic arst_n,
	sdm_if.sink in_ch,
	sdm_if.source out_ch
);
	localparam int K = 4;
	localparam int NS = 64 / K;

	logic en;
	logic [NS:0] vld_q;
	logic [63:0] rem [NS+1];
	logic [63:0] num [NS+1];
	logic [63:0] den [NS+1];
	sdm_pkg::ctl_t ctl [NS+1];
	logic [63:0] an, ad;
	sdm_pkg::ctl_t pctl;
	sdm_pkg::rsp_t rsp_q;
	logic out_v_q;

	// whole pipe advances unless the output holds an untaken item
	assign en = !out_v_q || out_ch.ready;
	assign in_ch.ready = en;
	assign out_ch.valid = out_v_q;
	assign out_ch.data = rsp_q;

	sdm_pre u_pre (.req(in_ch.data), .an(an), .ad(ad), .ctl(pctl));

	always_ff @(posedge clk) begin
		if (en) begin
			rem[0] <= '0;
			num[0] <= an;
			den[0] <= ad;
			ctl[0] <= pctl;
		end
	end

	for (genvar g = 0; g < NS; g++) begin : g_st
		sdm_stage #(.K(K)) u_st (
			.clk(clk), .en(en),
			.rem_i(rem[g]), .num_i(num[g]), .den_i(den[g]), .ctl_i(ctl[g]),
			.rem_s1(rem[g+1]), .num_s1(num[g+1]), .den_s1(den[g+1]), .ctl_s1(ctl[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[NS-1:0], in_ch.valid};
			out_v_q <= vld_q[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl[NS].special) begin
				rsp_q.quotient <= ctl[NS].sq;
				rsp_q.remainder <= ctl[NS].sr;
			end else begin
				rsp_q.quotient <= ctl[NS].qneg ? 64'(-num[NS]) : num[NS];
				rsp_q.remainder <= ctl[NS].rneg ? 64'(-rem[NS]) : rem[NS];
			end
			rsp_q.zero_divisor <= ctl[NS].zflag;
		end
	end

	// a stalled result must hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ch.ready |=> out_v_q && $stable(rsp_q))
		else $error("result changed under stall");
	// accepted item enters the valid chain at the pipe head
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> vld_q[0])
		else $error("accepted item lost at pipe entry");
	// ready follows the output register state
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |-> in_ch.ready)
		else $error("ready low with empty output");
endmodule

// ===== bench/signed_divider_with_modes_top_test.sv =====
// Testbench for signed_divider_with_modes_top: directed and random divisions
// checked against a predictor here. Depends on sdm_pkg, sdm_if and the DUT.
module signed_divider_with_modes_top_test;
	logic clk = 0;
	logic arst_n = 0;
	int errors = 0;

	sdm_if #(.T(sdm_pkg::req_t)) in_ch (clk);
	sdm_if #(.T(sdm_pkg::rsp_t)) out_ch (clk);

	signed_divider_with_modes_top uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// results the block still owes, oldest first
	sdm_pkg::rsp_t owed_q[$];

	function automatic logic [63:0] sx32(logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	// expected result of one division
	function automatic sdm_pkg::rsp_t divide(sdm_pkg::req_t r);
		sdm_pkg::rsp_t o;
		logic [63:0] n, d, an, ad, uq, ur, q, rm;
		if (r.op[0]) begin
			n = r.numerator; d = sx32(r.denominator);
		end else if (r.op[1]) begin
			n = r.numerator; d = r.denominator;
		end else begin
			n = sx32(r.numerator); d = sx32(r.denominator);
		end
		if (d == 64'd0) begin
			// divide by zero: sign-dependent fixed quotient, remainder is dividend
			q = n[63] ? 64'd1 : '1;
			if (r.op == sdm_pkg::OP_32_32) q = q ^ sdm_pkg::HIGH_WORD;
			rm = n;
		end else if (r.op == sdm_pkg::OP_32_32 && n[31:0] == 32'h8000_0000 && d == '1) begin
			q = sdm_pkg::MODE0_OVF_QUO; rm = '0;
		end else if (n == sdm_pkg::SIGN64 && d == '1) begin
			q = sdm_pkg::SIGN64; rm = '0;
		end else begin
			an = n[63] ? -n : n;
			ad = d[63] ? -d : d;
			uq = an / ad;
			ur = an % ad;
			q = (n[63] != d[63]) ? -uq : uq;
			rm = n[63] ? -ur : ur;
		end
		o.quotient = q;
		o.remainder = rm;
		o.zero_divisor = (r.denominator == 64'd0);
		return o;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// sender: bursts with random gaps
	int burst_left = 0;
	task automatic send(logic [1:0] op, logic [63:0] n, logic [63:0] d);
		sdm_pkg::req_t r;
		int gap;
		if (burst_left == 0) burst_left = $urandom_range(1, 20);
		r.op = op; r.numerator = n; r.denominator = d;
		in_ch.data <= r;
		in_ch.valid <= 1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		owed_q.push_back(divide(r));
		burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				in_ch.valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// receiver stall pattern: runs of ready and stalls of random length
	initial begin
		out_ch.ready <= 0;
		@(posedge arst_n);
		forever begin
			out_ch.ready <= 1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			out_ch.ready <= 0;
			repeat ($urandom_range(1, 1 + 3 * $urandom_range(0, 3))) @(posedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		sdm_pkg::rsp_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (owed_q.size() == 0) begin
				report("result with nothing owed", out_ch.data.quotient, 64'd0);
			end else begin
				want = owed_q.pop_front();
				if (out_ch.data.quotient !== want.quotient)
					report("quotient", out_ch.data.quotient, want.quotient);
				if (out_ch.data.remainder !== want.remainder)
					report("remainder", out_ch.data.remainder, want.remainder);
				if (out_ch.data.zero_divisor !== want.zero_divisor)
					report("zero_divisor", 64'(out_ch.data.zero_divisor),
						64'(want.zero_divisor));
			end
		end
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// operand with a bias toward edges and small magnitudes
	function automatic logic [63:0] pick();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return '1;
			2: return sdm_pkg::SIGN64;
			3: return sx32({$urandom, $urandom} & 64'hFFFF_FFFF);
			4: return {$urandom, 32'h0000_0000};
			5: return 64'($signed($urandom_range(0, 40)) - 20);
			6: return 64'h0000_0000_8000_0000;
			default: return rnd64();
		endcase
	endfunction

	task automatic test_edges();
		logic [63:0] vals[8];
		vals = '{64'd0, 64'd1, '1, sdm_pkg::SIGN64, 64'h7FFF_FFFF_FFFF_FFFF,
			64'h0000_0000_8000_0000, 64'hFFFF_FFFF_8000_0000, 64'h1_0000_0000};
		for (int m = 0; m < 4; m++) begin
			send(2'(m), vals[3], '1);           // full-width overflow, except mode 0
			send(2'(m), vals[5], '1);           // low-word overflow, mode 0 only
			send(2'(m), vals[2], 64'd0);        // zero divisor, negative dividend
			send(2'(m), vals[4], vals[7]);      // low word zero, flag clear
		end
		send(sdm_pkg::OP_64_64, 64'd7, 64'hFFFF_FFFF_FFFF_FFFE);
		send(sdm_pkg::OP_32_32, 64'h1234_5678_FFFF_FFF9, 64'h0000_0000_0000_0002);
		send(sdm_pkg::OP_64_32, vals[4], vals[6]);
		send(sdm_pkg::OP_64_32B, vals[3], vals[1]);
	endtask

	task automatic test_random(int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 1)) send(2'($urandom_range(0, 3)), rnd64(), rnd64());
			else send(2'($urandom_range(0, 3)), pick(), pick());
		end
	endtask

	// hold off until the pipe has drained
	task automatic test_drain_pause();
		in_ch.valid <= 0;
		burst_left = 0;
		while (owed_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		in_ch.valid <= 0;
		in_ch.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_edges();
		test_random(500);
		test_drain_pause();
		test_random(530);
		in_ch.valid <= 0;
		while (owed_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) $display("signed_divider_with_modes_top_test: clean");
		else $display("signed_divider_with_modes_top_test: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("signed_divider_with_modes_top_test: errors");
		$finish;
	end
endmodule
